/* design/gsf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the Gaussian smoothing FIR.
// ----------------------------------------------------------------------------
package gsf_pkg;

  localparam int MAX_RADIUS   = 6;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;

  localparam int WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int NUM_REGS     = MAX_RADIUS + 2;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int RADIUS_W     = 3;
  localparam int CIDX_W       = $clog2(MAX_RADIUS + 1);
  localparam int WIDX_W       = $clog2(WIN_DEPTH);
  localparam int TAP_W        = $clog2(WIN_DEPTH);
  localparam int PEND_W       = 3;
  localparam int CFG_DATA_W   = (COEF_WIDTH > RADIUS_W) ? COEF_WIDTH : RADIUS_W;

  // signed sample times zero-extended coefficient, then headroom for the taps
  localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH + 1;
  localparam int ACC_WIDTH    = PROD_W + $clog2(WIN_DEPTH);
  localparam int SH_W         = ACC_WIDTH - COEF_WIDTH;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RADIUS      = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COEF_CENTER = REG_IDX_W'(1);

  typedef struct packed {
    logic accept;       // shift a new sample into the window
    logic mac_start;    // clear accumulator and tap counter
    logic mac_step;     // multiply one tap and advance the tap counter
    logic out_load;     // load the output register, retire one owed output
    logic clear_valid;  // end of block: drop window contents and pending count
  } gsf_cmd_t;

  typedef struct packed {
    logic emit_needed;  // an owed output is due now
    logic last_tap;     // the tap being issued is the last of the kernel
    logic out_free;     // the output register can take a new result
    logic flush;        // current sample ended a block
    logic more;         // more than one output still owed
  } gsf_stat_t;

endpackage : gsf_pkg
`default_nettype wire

/* design/gsf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_ctrl
// Sequencer: accepts one sample, runs the multiply-accumulate over the kernel
// for every owed output, and hands each result to the output register.
// ----------------------------------------------------------------------------
module gsf_ctrl
  import gsf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire gsf_stat_t stat,
  output gsf_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MAC   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.emit_needed) begin
          cmd.mac_start = 1'b1;
          state_nxt     = S_MAC;
        end else begin
          cmd.clear_valid = stat.flush;
          state_nxt       = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (stat.last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.flush && stat.more) begin
            cmd.mac_start = 1'b1;
            state_nxt     = S_MAC;
          end else begin
            cmd.clear_valid = stat.flush;
            state_nxt       = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : gsf_ctrl
`default_nettype wire

/* design/gsf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_datapath
// Sample window, configuration registers, shared multiplier and accumulator,
// round/saturate stage and output register.
// ----------------------------------------------------------------------------
module gsf_datapath
  import gsf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [REG_IDX_W-1:0]    cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                    in_final,
  input  wire gsf_cmd_t                cmd,
  output gsf_stat_t                    stat,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [SAMPLE_WIDTH-1:0]      out_sample,
  output logic                         out_final
);

  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(2 ** (SAMPLE_WIDTH - 1));
  localparam logic signed [ACC_WIDTH-1:0] ROUND_ADD = ACC_WIDTH'(2 ** (COEF_WIDTH - 1));
  localparam logic [RADIUS_W-1:0] MAX_R = RADIUS_W'(MAX_RADIUS);
  localparam logic [TAP_W-1:0]    LAST_POS = TAP_W'(WIN_DEPTH - 1);

  // configuration
  logic [RADIUS_W-1:0]   radius_r;
  logic [COEF_WIDTH-1:0] coef_r [MAX_RADIUS+1];

  // window, newest sample at position 0
  logic signed [SAMPLE_WIDTH-1:0] win_r [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]           valid_r;
  logic [PEND_W-1:0]              pending_r;
  logic                           fin_r;

  // MAC
  logic [TAP_W-1:0]            tap_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic                        prod_vld_r;
  logic signed [ACC_WIDTH-1:0] acc_r;

  // output register
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;
  logic                    out_last_r;

  logic [RADIUS_W-1:0]         eff_rad;
  logic [PEND_W-1:0]           center;
  logic signed [TAP_W:0]       tap_pos;
  logic                        tap_ok;
  logic [CIDX_W-1:0]           tap_dist;
  logic signed [PROD_W-1:0]    prod_c;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [SH_W-1:0]      shifted;
  logic [SAMPLE_WIDTH-1:0]     sat;
  logic                        last_nxt;

  assign eff_rad = (radius_r > MAX_R) ? MAX_R : radius_r;
  assign center  = pending_r - PEND_W'(1);

  // tap k covers offset d = k - r, window position center - d
  assign tap_pos = $signed((TAP_W + 1)'(center)) + $signed((TAP_W + 1)'(eff_rad))
                   - $signed((TAP_W + 1)'(tap_r));
  assign tap_ok  = !tap_pos[TAP_W] && (tap_pos[TAP_W-1:0] <= LAST_POS)
                   && valid_r[tap_pos[WIDX_W-1:0]];
  assign tap_dist = (tap_r >= TAP_W'(eff_rad)) ? CIDX_W'(tap_r - TAP_W'(eff_rad))
                                               : CIDX_W'(TAP_W'(eff_rad) - tap_r);

  always_comb begin
    prod_c = '0;
    if (tap_ok) begin
      prod_c = win_r[tap_pos[WIDX_W-1:0]] * $signed({1'b0, coef_r[tap_dist]});
    end
  end

  // round half up, floor shift, saturate
  assign rnd     = acc_r + ROUND_ADD;
  assign shifted = rnd[ACC_WIDTH-1:COEF_WIDTH];
  always_comb begin
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  assign last_nxt = fin_r && (pending_r == PEND_W'(1));

  assign stat.emit_needed = fin_r ? (pending_r != '0) : (pending_r > PEND_W'(eff_rad));
  assign stat.last_tap    = (tap_r == TAP_W'({eff_rad, 1'b0}));
  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.flush       = fin_r;
  assign stat.more        = (pending_r > PEND_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      for (int i = 0; i <= MAX_RADIUS; i++) begin
        coef_r[i] <= (i == 0) ? '1 : '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIUS: radius_r <= cfg_wdata[RADIUS_W-1:0];
        default:    coef_r[CIDX_W'(cfg_addr - REG_COEF_CENTER)] <= cfg_wdata[COEF_WIDTH-1:0];
      endcase
    end
  end

  // window payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r[0] <= in_sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // window control and owed-output count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      pending_r <= '0;
      fin_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        valid_r   <= {valid_r[WIN_DEPTH-2:0], 1'b1};
        pending_r <= pending_r + PEND_W'(1);
        fin_r     <= in_final;
      end else if (cmd.clear_valid) begin
        valid_r   <= '0;
        pending_r <= '0;
      end else if (cmd.out_load) begin
        pending_r <= pending_r - PEND_W'(1);
      end
    end
  end

  // shared multiply-accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      tap_r      <= '0;
    end else begin
      prod_vld_r <= cmd.mac_step;
      if (cmd.mac_start) begin
        tap_r <= '0;
      end else if (cmd.mac_step) begin
        tap_r <= tap_r + TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_step) begin
      prod_r <= prod_c;
    end
    if (cmd.mac_start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_WIDTH'(prod_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= sat;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_sample = out_data_r;
  assign out_final  = out_last_r;

`ifndef SYNTHESIS
  a_tap_in_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_step |-> (tap_r <= TAP_W'({eff_rad, 1'b0})))
    else $error("tap counter ran past the kernel");

  a_mac_has_owed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_step |-> (pending_r != '0))
    else $error("multiply-accumulate with nothing owed");

  a_no_accept_mid_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!prod_vld_r && !cmd.out_load))
    else $error("sample taken while an output is in progress");

  a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && last_nxt) |=> (valid_r == '0 && pending_r == '0))
    else $error("window not cleared after the last output of a block");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_data_r) && $stable(out_last_r)))
    else $error("output register overwritten while stalled");
`endif

endmodule : gsf_datapath
`default_nettype wire

/* design/gaussian_smoothing_fir.sv */
`default_nettype none
// Flow: an accepted sample passes S_CHECK and, if it releases an output, S_MAC,
//   S_DRAIN and S_EMIT, which loads the output register. A new sample is taken
//   only once the previous one is done; on a flush each further owed output
//   repeats the S_MAC pass. The single shared multiplier walks all 2*radius+1
//   taps of the kernel, one per cycle; a stalled sink adds its stall.
// Reset: synchronous, active-low rst_n clears the window, owed count and
//   output valid, and loads radius 0, center weight 65535, other weights 0.
// ----------------------------------------------------------------------------
// gaussian_smoothing_fir
// Streaming 1-D Gaussian smoothing filter with a symmetric, register-set
// kernel, zero taps outside the block, rounding and saturation.
// ----------------------------------------------------------------------------
module gaussian_smoothing_fir
  import gsf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [REG_IDX_W-1:0]    cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [SAMPLE_WIDTH-1:0] in_tdata,   // [15:0] sample
  input  wire logic                    in_tlast,   // final_sample
  // result stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [SAMPLE_WIDTH-1:0]      out_tdata,  // [15:0] smoothed
  output logic                         out_tlast   // final_result
);

  // Command and status between the sequencer and the datapath.
  gsf_cmd_t  cmd;
  gsf_stat_t stat;

  // Sequencer: takes one request at a time; while it works on the MAC the
  // input side holds ready low. A finished result waits in the output
  // register, so the next request is taken even if the sink stalls.
  gsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the window shifts on each accepted request; for each owed
  // output the multiplier walks the taps, the accumulator sums them, and the
  // rounded, saturated value lands in the output register. The request that
  // ends a block drains every owed output, oldest first, and marks the last.
  gsf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata),
    .in_final   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (out_tdata),
    .out_final  (out_tlast)
  );

endmodule : gaussian_smoothing_fir
`default_nettype wire
